// ===== hw/rtl/lik_pkg.sv =====
// ----------------------------------------------------------------------------
// lik_pkg: shared constants and tables for the leg inverse kinematics block
// Field widths, datapath widths, pipeline depth, register codes, atan table.
// ----------------------------------------------------------------------------
package lik_pkg;

	// vectoring steps of every cordic unit (8 to 24)
	localparam int CORDIC_STEPS = 16;

	// item and register field widths
	localparam int TGT_W      = 13;
	localparam int LEN_W      = 12;
	localparam int OFF_W      = 13;
	localparam int JOINT_W    = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// reset values of the registers
	localparam logic [LEN_W-1:0] COXA_RST  = 12'd849;
	localparam logic [LEN_W-1:0] FEMUR_RST = 12'd996;
	localparam logic [LEN_W-1:0] TIBIA_RST = 12'd2176;
	localparam logic [OFF_W-1:0] OFFS_RST  = 13'd941;

	// digits of the reach root and of the two acos roots
	localparam int R_DIG = 13;
	localparam int R_W   = 2 * R_DIG;
	localparam int A_DIG = 26;
	localparam int A_W   = 2 * A_DIG;

	// cordic datapath
	localparam int VEC_W = 30;
	localparam int CV_W  = 34;
	localparam int ANG_W = 28;
	localparam int CORDIC_LAT = 2 + CORDIC_STEPS;

	// stages: inputs, squares, sum, reach root, six leg-plane stages,
	// acos roots, cordic input, cordic, combine, output
	localparam int PIPE_DEPTH = 3 + R_DIG + 6 + A_DIG + 1 + CORDIC_LAT + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COXA   = 2'd0,
		REG_FEMUR  = 2'd1,
		REG_TIBIA  = 2'd2,
		REG_OFFSET = 2'd3
	} cfg_reg_t;

	// round(atan(2^-i) * 2^24)
	function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
		case (i)
			0:  return 28'sd13176795;
			1:  return 28'sd7778716;
			2:  return 28'sd4110060;
			3:  return 28'sd2086331;
			4:  return 28'sd1047214;
			5:  return 28'sd524117;
			6:  return 28'sd262123;
			7:  return 28'sd131069;
			8:  return 28'sd65536;
			9:  return 28'sd32768;
			10: return 28'sd16384;
			11: return 28'sd8192;
			12: return 28'sd4096;
			13: return 28'sd2048;
			14: return 28'sd1024;
			15: return 28'sd512;
			16: return 28'sd256;
			17: return 28'sd128;
			18: return 28'sd64;
			19: return 28'sd32;
			20: return 28'sd16;
			21: return 28'sd8;
			22: return 28'sd4;
			23: return 28'sd2;
			default: return '0;
		endcase
	endfunction

endpackage

// ===== hw/rtl/lik_target_if.sv =====
// ----------------------------------------------------------------------------
// lik_target_if: foot target channel
// Valid/ready channel carrying one foot target item.
// ----------------------------------------------------------------------------
interface lik_target_if;
	import lik_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [TGT_W-1:0] target_x;
	logic signed [TGT_W-1:0] target_y;
	logic signed [TGT_W-1:0] target_z;

	modport source (output valid, output target_x, output target_y, output target_z,
		input ready);
	modport sink (input valid, input target_x, input target_y, input target_z,
		output ready);
endinterface

// ===== hw/rtl/lik_joint_if.sv =====
// ----------------------------------------------------------------------------
// lik_joint_if: joint angle channel
// Valid/ready channel carrying one set of joint angles.
// ----------------------------------------------------------------------------
interface lik_joint_if;
	import lik_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [JOINT_W-1:0] hip_angle;
	logic signed [JOINT_W-1:0] femur_angle;
	logic signed [JOINT_W-1:0] tibia_angle;
	logic                      unreachable;

	modport source (output valid, output hip_angle, output femur_angle,
		output tibia_angle, output unreachable, input ready);
	modport sink (input valid, input hip_angle, input femur_angle,
		input tibia_angle, input unreachable, output ready);
endinterface

// ===== hw/rtl/lik_cordic.sv =====
// ----------------------------------------------------------------------------
// lik_cordic: pipelined vectoring cordic
// atan2(y, x) for x >= 0 in 2^-24 rad; normalizes, then one step per stage.
// ----------------------------------------------------------------------------
module lik_cordic (
	input  logic                              clk,
	input  logic                              en,
	input  logic [lik_pkg::VEC_W-1:0]         vec_x,
	input  logic signed [lik_pkg::VEC_W:0]    vec_y,
	output logic signed [lik_pkg::ANG_W-1:0]  angle
);
	import lik_pkg::*;

	localparam int SH_W = $clog2(VEC_W);

	logic [VEC_W-1:0]        ay;
	logic [VEC_W-1:0]        mag;
	logic [SH_W-1:0]         sh;
	logic [VEC_W-1:0]        x_n1;
	logic signed [VEC_W:0]   y_n1;
	logic [SH_W-1:0]         sh_n1;
	logic                    zero_n1;
	logic signed [CV_W-1:0]  cx [CORDIC_STEPS+1];
	logic signed [CV_W-1:0]  cy [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] cz [CORDIC_STEPS+1];
	logic                    zf [CORDIC_STEPS+1];

	// leading one search on the larger component
	always_comb begin
		ay  = vec_y[VEC_W] ? VEC_W'(-vec_y) : VEC_W'(vec_y);
		mag = (vec_x > ay) ? vec_x : ay;
		sh  = '0;
		for (int i = 0; i < VEC_W; i++) begin
			if (mag[i]) sh = SH_W'(VEC_W - 1 - i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_n1    <= vec_x;
			y_n1    <= vec_y;
			sh_n1   <= sh;
			zero_n1 <= (vec_x == '0) && (vec_y == '0);
		end
	end

	// scale so the larger component sits in [2^29, 2^30)
	always_ff @(posedge clk) begin
		if (en) begin
			cx[0] <= $signed(CV_W'(x_n1) << sh_n1);
			cy[0] <= CV_W'(y_n1) <<< sh_n1;
			cz[0] <= '0;
			zf[0] <= zero_n1;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				zf[i+1] <= zf[i];
				if (cy[i] > 0) begin
					cx[i+1] <= cx[i] + (cy[i] >>> i);
					cy[i+1] <= cy[i] - (cx[i] >>> i);
					cz[i+1] <= cz[i] + atan_entry(i);
				end else begin
					cx[i+1] <= cx[i] - (cy[i] >>> i);
					cy[i+1] <= cy[i] + (cx[i] >>> i);
					cz[i+1] <= cz[i] - atan_entry(i);
				end
			end
		end
	end

	// a zero vector has angle zero
	assign angle = zf[CORDIC_STEPS] ? '0 : cz[CORDIC_STEPS];

endmodule

// ===== hw/rtl/leg_inverse_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// leg_inverse_kinematics_top: three joint leg inverse kinematics
// Foot target in 1/16 mm to hip, femur and tibia angles in 1/4096 rad.
// ----------------------------------------------------------------------------
// usage
// - target channel takes one foot target item (x, y, z) per cycle while target ready is high
// - joint channel returns one item with three angles and an unreachable flag
//   for every target, in the order the targets came in
// - the pipeline is 53 + CORDIC_STEPS register stages (69 at 16 steps); the
//   joint channel is driven from the last stage's registers; throughput is one
//   item a cycle while the joint receiver keeps ready high
// - the depth comes from the 13 digit reach root, the two 26 digit acos roots
//   and the cordic chains, one digit or one rotation per stage
// - the whole pipeline moves as one; when the joint receiver holds ready low
//   with a result waiting, every stage holds and target ready drops, so
//   nothing is lost or repeated
// - reset clears the valid bits and loads the link registers with their
//   default lengths and offset; no clearing pass is needed
// - config writes (cfg_we, cfg_index, cfg_data) are registered and not gated by
//   the block; the user must make them while the pipeline is empty
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_top (
	input  logic                              clk,
	input  logic                              arst_n,
	lik_target_if.sink                        target,
	lik_joint_if.source                       joint,
	input  logic                              cfg_we,
	input  logic [lik_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lik_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lik_pkg::*;

	localparam int SQ_W   = 25;
	localparam int JE_W   = 14;
	localparam int S_W    = 26;
	localparam int MAG_W  = 27;
	localparam int NUM_W  = 28;
	localparam int NSQ_W  = 54;
	localparam int SUM_W  = 30;
	localparam int ST_ROOT_R = 3 + R_DIG;
	localparam logic signed [ANG_W-1:0] HALF_PI = 28'sd26353589;
	localparam logic signed [ANG_W-1:0] PI_ANG  = 28'sd52707179;
	localparam int HIP_BOUND = 6434 + (4096 >> (CORDIC_STEPS - 1)) + 2;

	typedef struct packed {
		logic signed [TGT_W-1:0] y;
		logic [TGT_W-1:0]        ax;
		logic [TGT_W-1:0]        az;
		logic [SQ_W-1:0]         z2;
		logic                    zxy;
	} side_a_t;

	typedef struct packed {
		logic signed [TGT_W-1:0] y;
		logic [TGT_W-1:0]        ax;
		logic [TGT_W-1:0]        az;
		logic signed [JE_W-1:0]  je;
		logic                    bad;
	} side_b_t;

	typedef struct packed {
		logic signed [TGT_W-1:0] y;
		logic [TGT_W-1:0]        ax;
		logic [TGT_W-1:0]        az;
		logic signed [JE_W-1:0]  je;
		logic                    bad;
		logic                    bad1;
		logic                    neg1;
		logic [MAG_W-1:0]        mag1;
		logic                    bad2;
		logic                    neg2;
		logic [MAG_W-1:0]        mag2;
	} side_c_t;

	typedef struct packed {
		logic bad;
		logic bad1;
		logic neg1;
		logic bad2;
		logic neg2;
	} side_d_t;

	// config and derived link terms
	logic [LEN_W-1:0]     coxa_q, femur_q, tibia_q;
	logic [OFF_W-1:0]     offs_q;
	logic [2*LEN_W-1:0]   f2_q, t2_q, tf_q;
	logic [A_W-3:0]       den2_q;

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;

	logic signed [TGT_W-1:0] x_s1, y_s1, z_s1;
	logic [SQ_W-1:0]         x2_s2, y2_s2, z2_s2;
	logic signed [TGT_W-1:0] y_s2;
	logic [TGT_W-1:0]        ax_s2, az_s2;
	logic                    zxy_s2;
	logic [R_W-1:0]          rsum_s3;
	side_a_t                 sa_s3;

	logic [R_W-1:0]          rv [R_DIG];
	logic [R_W-1:0]          rr [R_DIG];
	side_a_t                 da [R_DIG];

	logic signed [JE_W-1:0]  je_s17, je_s18;
	side_a_t                 sa_s17, sa_s18;
	logic [SQ_W-1:0]         je2_s18;
	logic [S_W-1:0]          s_sum;
	logic [S_W-1:0]          s_s19;
	side_b_t                 sb_s19, sb_s20, sb_s21;
	logic [A_W-3:0]          p_s20;
	logic signed [NUM_W-1:0] num1_s20, num2_s20;
	logic [MAG_W-1:0]        m1, m2;
	logic [A_W-1:0]          den1_s21, den2_s21;
	logic [NSQ_W-1:0]        nsq1_s21, nsq2_s21;
	logic                    neg1_s21, neg2_s21;
	logic [MAG_W-1:0]        mag1_s21, mag2_s21;
	logic                    bad1, bad2;
	logic [A_W-1:0]          diff1_s22, diff2_s22;
	side_c_t                 sc_s22;

	logic [A_W-1:0]          av1 [A_DIG];
	logic [A_W-1:0]          ar1 [A_DIG];
	logic [A_W-1:0]          av2 [A_DIG];
	logic [A_W-1:0]          ar2 [A_DIG];
	side_c_t                 db [A_DIG];

	logic [A_DIG-1:0]        root1, root2;
	logic [VEC_W-1:0]        hx_s49, jx_s49, ex_s49, bx_s49;
	logic signed [VEC_W:0]   hy_s49, jy_s49, ey_s49, by_s49;
	side_d_t                 fl_s49;
	side_d_t                 dc [CORDIC_LAT];

	logic signed [ANG_W-1:0] ang_hip, ang_jbe, ang_ebd, ang_bde;
	logic signed [ANG_W-1:0] ebd, bde;
	logic signed [SUM_W-1:0] off_ext;
	logic signed [SUM_W-1:0] hip_sc, fem_sc, tib_sc;
	logic                    bad_sc;
	logic signed [JOINT_W-1:0] hip_so, fem_so, tib_so;
	logic                    bad_so;

	// round half up to 1/4096 rad
	function automatic logic signed [JOINT_W-1:0] to_joint(input logic signed [SUM_W-1:0] a);
		logic signed [SUM_W-1:0] t;
		t = a + SUM_W'(2048);
		return t[12 +: JOINT_W];
	endfunction

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coxa_q  <= COXA_RST;
			femur_q <= FEMUR_RST;
			tibia_q <= TIBIA_RST;
			offs_q  <= OFFS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COXA:   coxa_q  <= cfg_data[LEN_W-1:0];
				REG_FEMUR:  femur_q <= cfg_data[LEN_W-1:0];
				REG_TIBIA:  tibia_q <= cfg_data[LEN_W-1:0];
				REG_OFFSET: offs_q  <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// squared link terms, settled long before an item needs them
	always_ff @(posedge clk) begin
		f2_q   <= (2*LEN_W)'(femur_q * femur_q);
		t2_q   <= (2*LEN_W)'(tibia_q * tibia_q);
		tf_q   <= (2*LEN_W)'(femur_q * tibia_q);
		den2_q <= (A_W-2)'({tf_q, 1'b0} * {tf_q, 1'b0});
	end

	// pipeline advance and valid chain
	assign en           = !vld_q[PIPE_DEPTH-1] || joint.ready;
	assign target.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], target.valid};
		end
	end

	// input, squares, reach sum
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= target.target_x;
			y_s1 <= target.target_y;
			z_s1 <= target.target_z;

			x2_s2  <= SQ_W'(x_s1 * x_s1);
			y2_s2  <= SQ_W'(y_s1 * y_s1);
			z2_s2  <= SQ_W'(z_s1 * z_s1);
			y_s2   <= y_s1;
			ax_s2  <= x_s1[TGT_W-1] ? TGT_W'(-x_s1) : TGT_W'(x_s1);
			az_s2  <= z_s1[TGT_W-1] ? TGT_W'(-z_s1) : TGT_W'(z_s1);
			zxy_s2 <= (x_s1 == '0) && (y_s1 == '0);

			rsum_s3   <= R_W'(x2_s2) + R_W'(y2_s2);
			sa_s3.y   <= y_s2;
			sa_s3.ax  <= ax_s2;
			sa_s3.az  <= az_s2;
			sa_s3.z2  <= z2_s2;
			sa_s3.zxy <= zxy_s2;
		end
	end

	// reach root, one digit per stage
	for (genvar k = 0; k < R_DIG; k++) begin : g_rroot
		localparam logic [R_W-1:0] DIG_B = R_W'(1) << (2 * (R_DIG - 1 - k));
		logic [R_W-1:0] v_in, r_in, tr;
		side_a_t        sa_in;
		if (k == 0) begin : g_first
			assign v_in  = rsum_s3;
			assign r_in  = '0;
			assign sa_in = sa_s3;
		end else begin : g_next
			assign v_in  = rv[k-1];
			assign r_in  = rr[k-1];
			assign sa_in = da[k-1];
		end
		assign tr = r_in + DIG_B;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= tr) begin
					rv[k] <= v_in - tr;
					rr[k] <= (r_in >> 1) + DIG_B;
				end else begin
					rv[k] <= v_in;
					rr[k] <= r_in >> 1;
				end
				da[k] <= sa_in;
			end
		end
	end

	// leg-plane distance squared
	assign s_sum = S_W'(sa_s18.z2) + S_W'(je2_s18);

	always_ff @(posedge clk) begin
		if (en) begin
			je_s17 <= $signed({1'b0, rr[R_DIG-1][R_DIG-1:0]}) - $signed({2'b00, coxa_q});
			sa_s17 <= da[R_DIG-1];

			je2_s18 <= SQ_W'(je_s17 * je_s17);
			je_s18  <= je_s17;
			sa_s18  <= sa_s17;

			s_s19      <= s_sum;
			sb_s19.y   <= sa_s18.y;
			sb_s19.ax  <= sa_s18.ax;
			sb_s19.az  <= sa_s18.az;
			sb_s19.je  <= je_s18;
			sb_s19.bad <= sa_s18.zxy || (s_sum == '0);
		end
	end

	// law of cosines terms
	assign m1 = num1_s20[NUM_W-1] ? MAG_W'(-num1_s20) : MAG_W'(num1_s20);
	assign m2 = num2_s20[NUM_W-1] ? MAG_W'(-num2_s20) : MAG_W'(num2_s20);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s20    <= (A_W-2)'(s_s19 * f2_q);
			num1_s20 <= $signed({2'b00, s_s19}) + $signed({4'b0000, f2_q})
				- $signed({4'b0000, t2_q});
			num2_s20 <= $signed({4'b0000, f2_q}) + $signed({4'b0000, t2_q})
				- $signed({2'b00, s_s19});
			sb_s20   <= sb_s19;

			den1_s21 <= {p_s20, 2'b00};
			den2_s21 <= A_W'(den2_q);
			nsq1_s21 <= NSQ_W'(m1 * m1);
			nsq2_s21 <= NSQ_W'(m2 * m2);
			neg1_s21 <= num1_s20[NUM_W-1];
			neg2_s21 <= num2_s20[NUM_W-1];
			mag1_s21 <= m1;
			mag2_s21 <= m2;
			sb_s21   <= sb_s20;
		end
	end

	// clamp checks and root arguments
	assign bad1 = (den1_s21 == '0) || (nsq1_s21 > NSQ_W'(den1_s21));
	assign bad2 = (den2_s21 == '0) || (nsq2_s21 > NSQ_W'(den2_s21));

	always_ff @(posedge clk) begin
		if (en) begin
			diff1_s22   <= den1_s21 - nsq1_s21[A_W-1:0];
			diff2_s22   <= den2_s21 - nsq2_s21[A_W-1:0];
			sc_s22.y    <= sb_s21.y;
			sc_s22.ax   <= sb_s21.ax;
			sc_s22.az   <= sb_s21.az;
			sc_s22.je   <= sb_s21.je;
			sc_s22.bad  <= sb_s21.bad || bad1 || bad2;
			sc_s22.bad1 <= bad1;
			sc_s22.neg1 <= neg1_s21;
			sc_s22.mag1 <= mag1_s21;
			sc_s22.bad2 <= bad2;
			sc_s22.neg2 <= neg2_s21;
			sc_s22.mag2 <= mag2_s21;
		end
	end

	// the two acos roots, one digit per stage
	for (genvar k = 0; k < A_DIG; k++) begin : g_aroot
		localparam logic [A_W-1:0] DIG_B = A_W'(1) << (2 * (A_DIG - 1 - k));
		logic [A_W-1:0] v1_in, r1_in, t1, v2_in, r2_in, t2;
		side_c_t        sc_in;
		if (k == 0) begin : g_first
			assign v1_in = diff1_s22;
			assign v2_in = diff2_s22;
			assign r1_in = '0;
			assign r2_in = '0;
			assign sc_in = sc_s22;
		end else begin : g_next
			assign v1_in = av1[k-1];
			assign v2_in = av2[k-1];
			assign r1_in = ar1[k-1];
			assign r2_in = ar2[k-1];
			assign sc_in = db[k-1];
		end
		assign t1 = r1_in + DIG_B;
		assign t2 = r2_in + DIG_B;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v1_in >= t1) begin
					av1[k] <= v1_in - t1;
					ar1[k] <= (r1_in >> 1) + DIG_B;
				end else begin
					av1[k] <= v1_in;
					ar1[k] <= r1_in >> 1;
				end
				if (v2_in >= t2) begin
					av2[k] <= v2_in - t2;
					ar2[k] <= (r2_in >> 1) + DIG_B;
				end else begin
					av2[k] <= v2_in;
					ar2[k] <= r2_in >> 1;
				end
				db[k] <= sc_in;
			end
		end
	end

	assign root1 = ar1[A_DIG-1][A_DIG-1:0];
	assign root2 = ar2[A_DIG-1][A_DIG-1:0];

	// cordic operands; a negative acos numerator turns into pi/2 + atan2
	always_ff @(posedge clk) begin
		if (en) begin
			hx_s49 <= VEC_W'(db[A_DIG-1].ax);
			hy_s49 <= (VEC_W+1)'(db[A_DIG-1].y);
			jx_s49 <= VEC_W'(db[A_DIG-1].az);
			jy_s49 <= (VEC_W+1)'(db[A_DIG-1].je);
			if (db[A_DIG-1].neg1) begin
				ex_s49 <= VEC_W'(root1);
				ey_s49 <= $signed((VEC_W+1)'(db[A_DIG-1].mag1));
			end else begin
				ex_s49 <= VEC_W'(db[A_DIG-1].mag1);
				ey_s49 <= $signed((VEC_W+1)'(root1));
			end
			if (db[A_DIG-1].neg2) begin
				bx_s49 <= VEC_W'(root2);
				by_s49 <= $signed((VEC_W+1)'(db[A_DIG-1].mag2));
			end else begin
				bx_s49 <= VEC_W'(db[A_DIG-1].mag2);
				by_s49 <= $signed((VEC_W+1)'(root2));
			end
			fl_s49.bad  <= db[A_DIG-1].bad;
			fl_s49.bad1 <= db[A_DIG-1].bad1;
			fl_s49.neg1 <= db[A_DIG-1].neg1;
			fl_s49.bad2 <= db[A_DIG-1].bad2;
			fl_s49.neg2 <= db[A_DIG-1].neg2;
		end
	end

	lik_cordic u_hip (.clk(clk), .en(en), .vec_x(hx_s49), .vec_y(hy_s49), .angle(ang_hip));
	lik_cordic u_jbe (.clk(clk), .en(en), .vec_x(jx_s49), .vec_y(jy_s49), .angle(ang_jbe));
	lik_cordic u_ebd (.clk(clk), .en(en), .vec_x(ex_s49), .vec_y(ey_s49), .angle(ang_ebd));
	lik_cordic u_bde (.clk(clk), .en(en), .vec_x(bx_s49), .vec_y(by_s49), .angle(ang_bde));

	// flags ride alongside the cordic units
	always_ff @(posedge clk) begin
		if (en) begin
			dc[0] <= fl_s49;
			for (int k = 1; k < CORDIC_LAT; k++) begin
				dc[k] <= dc[k-1];
			end
		end
	end

	// acos terms with clamping
	always_comb begin
		if (dc[CORDIC_LAT-1].bad1) begin
			ebd = dc[CORDIC_LAT-1].neg1 ? PI_ANG : '0;
		end else begin
			ebd = dc[CORDIC_LAT-1].neg1 ? HALF_PI + ang_ebd : ang_ebd;
		end
		if (dc[CORDIC_LAT-1].bad2) begin
			bde = dc[CORDIC_LAT-1].neg2 ? PI_ANG : '0;
		end else begin
			bde = dc[CORDIC_LAT-1].neg2 ? HALF_PI + ang_bde : ang_bde;
		end
	end

	assign off_ext = $signed({{(SUM_W-OFF_W-12){1'b0}}, offs_q, 12'h000});

	// joint sums, then rounding into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			hip_sc <= SUM_W'(ang_hip);
			fem_sc <= off_ext + SUM_W'(ang_jbe) + SUM_W'(ebd) - SUM_W'(HALF_PI);
			tib_sc <= SUM_W'(HALF_PI) + off_ext - SUM_W'(bde);
			bad_sc <= dc[CORDIC_LAT-1].bad;

			hip_so <= to_joint(hip_sc);
			fem_so <= to_joint(fem_sc);
			tib_so <= to_joint(tib_sc);
			bad_so <= bad_sc;
		end
	end

	assign joint.valid       = vld_q[PIPE_DEPTH-1];
	assign joint.hip_angle   = hip_so;
	assign joint.femur_angle = fem_so;
	assign joint.tibia_angle = tib_so;
	assign joint.unreachable = bad_so;

	// a held pipeline keeps its occupancy
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

	// zero reach only when x and y are both zero
	a_reach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_ROOT_R-1] |-> ((rr[R_DIG-1] == '0) == da[R_DIG-1].zxy))
		else $error("reach root disagrees with zero target flag");

	// hip angle stays within a quarter turn
	a_hip_range: assert property (@(posedge clk) disable iff (!arst_n)
		joint.valid |-> (joint.hip_angle <= JOINT_W'(HIP_BOUND))
			&& (joint.hip_angle >= -JOINT_W'(HIP_BOUND)))
		else $error("hip angle beyond a quarter turn");

endmodule
